>>> hdl/dc_pkg.sv
package dc_pkg;

    // Fixed field widths of the stream payloads
    localparam int NUMBER_WIDTH = 16;
    localparam int COUNT_WIDTH  = 8;

    // Largest divisor count the result field can carry; larger counts clamp here
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 8'd255;

endpackage

>>> hdl/dc_divider.sv
module dc_divider import dc_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_WIDTH = $clog2(WIDTH + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [WIDTH:0]       rem_reg;
    logic [WIDTH-1:0]     quot_reg;

    logic [WIDTH:0]       shifted;
    logic [WIDTH:0]       diff;
    logic                 fits;

    // One restoring step: bring down the next dividend bit, try a subtract
    assign shifted = {rem_reg[WIDTH-1:0], quot_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = ~diff[WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff : shifted;
            quot_reg <= {quot_reg[WIDTH-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[WIDTH-1:0];

endmodule

>>> hdl/divisor_count.sv
// Divisor counter: each beat on the s_ side carries one unsigned number, and exactly one
// beat on the m_ side returns how many positive divisors it has (tuser bit 0 flags a zero
// input, which returns a count of zero). Only the low VALUE_BITS bits of the number are
// used, capped at the 16-bit field. The block runs trial division with a shared
// bit-serial restoring divider: every candidate divisor d with d*d <= m costs one
// W-bit division (W = effective width) plus a pass through the check and start states,
// and each time d divides the cofactor it costs one more division. A 16-bit prime near
// 65535 tries 254 divisors; an input of zero goes straight from idle to the finish
// state, and an input of one passes through a single check on the way.
// One number is in work at a time; s_tready is high only while the sequencer is free,
// and a finished result waits in the output register while the next number is taken.
module divisor_count import dc_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [NUMBER_WIDTH-1:0] s_tdata,   // [15:0] number
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [COUNT_WIDTH-1:0]  m_tdata,   // [7:0] divisor_count
    output logic [0:0]              m_tuser    // [0] bad_input
);

    // Effective working width: the parameter, but never more than the input field
    localparam int W       = (VALUE_BITS < NUMBER_WIDTH) ? VALUE_BITS : NUMBER_WIDTH;
    // Exponent plus one reaches at most W
    localparam int E_WIDTH = $clog2(W + 2);
    localparam int P_WIDTH = COUNT_WIDTH + E_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [W-1:0]           m_reg;      // cofactor still to be split
    logic [W-1:0]           d_reg;      // current trial divisor
    logic [W:0]             dsq_reg;    // d_reg squared, kept by increments
    logic [E_WIDTH-1:0]     e_reg;      // exponent of d_reg plus one
    logic [COUNT_WIDTH-1:0] total_reg;  // running product, clamped
    logic                   bad_reg;
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   out_bad_reg;

    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    logic [W-1:0]           div_quot;
    logic [W-1:0]           div_rem;
    logic [E_WIDTH-1:0]     mul_factor;
    logic [P_WIDTH-1:0]     product;
    logic [COUNT_WIDTH-1:0] total_sat;
    logic                   loop_go;

    assign accept    = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_DIV_START);
    assign loop_go   = (dsq_reg <= {1'b0, m_reg});

    // Multiply the running count by the exponent term; at loop end the leftover
    // cofactor above one is a single prime and doubles the count
    always_comb
    begin
        if (state_reg == ST_CHECK)
            mul_factor = (m_reg > W'(1)) ? E_WIDTH'(2) : E_WIDTH'(1);
        else
            mul_factor = e_reg;
        product = P_WIDTH'(total_reg) * P_WIDTH'(mul_factor);
        if (product > P_WIDTH'(COUNT_MAX))
            total_sat = COUNT_MAX;
        else
            total_sat = product[COUNT_WIDTH-1:0];
    end

    dc_divider #(
        .WIDTH (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (m_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a finished result, or drop the held one once downstream takes it
            if (state_reg == ST_FINISH && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= (s_tdata[W-1:0] == '0) ? ST_FINISH : ST_CHECK;
                end
                ST_CHECK:
                begin
                    state_reg <= loop_go ? ST_DIV_START : ST_FINISH;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= (div_rem == '0) ? ST_DIV_START : ST_CHECK;
                end
                ST_FINISH:
                begin
                    // Hold until the output register is free
                    if (!out_valid_reg || m_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers follow the sequencer; no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    m_reg     <= s_tdata[W-1:0];
                    d_reg     <= W'(2);
                    dsq_reg   <= (W + 1)'(4);
                    e_reg     <= E_WIDTH'(1);
                    total_reg <= (s_tdata[W-1:0] == '0) ? '0 : COUNT_WIDTH'(1);
                    bad_reg   <= (s_tdata[W-1:0] == '0);
                end
            end
            ST_CHECK:
            begin
                if (!loop_go)
                    total_reg <= total_sat;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        m_reg <= div_quot;
                        e_reg <= e_reg + 1'b1;
                    end
                    else
                    begin
                        // Advance to the next trial divisor: (d+1)^2 = d^2 + 2d + 1
                        total_reg <= total_sat;
                        e_reg     <= E_WIDTH'(1);
                        d_reg     <= d_reg + 1'b1;
                        dsq_reg   <= dsq_reg + {d_reg, 1'b1};
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_count_reg <= total_reg;
                    out_bad_reg   <= bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_count_reg;
    assign m_tuser[0] = out_bad_reg;

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("flagged result carries a nonzero count");

    a_good_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata != '0))
        else $error("valid input produced a zero count");

    a_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while not awaited");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken again before the number was worked");

endmodule

>>> sim/divisor_count_checker.sv
`timescale 1ns / 100ps

module divisor_count_checker import dc_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [NUMBER_WIDTH-1:0] s_tdata,   // [15:0] number
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [COUNT_WIDTH-1:0]  m_tdata,   // [7:0] divisor_count
    input  logic [0:0]              m_tuser,   // [0] bad_input
    output int                      mismatches,
    output int                      outstanding
);

    // Only the low VALUE_BITS bits of a number count, never more than the field
    localparam longint unsigned VALUE_MASK = ((64'd1 << VALUE_BITS) - 64'd1) & 64'hFFFF;

    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] number;
        logic [COUNT_WIDTH-1:0]  count;
        logic                    bad_input;
    } divisor_result_t;

    divisor_result_t pending_counts [$];

    // Trial division up to the square root; a cofactor left over is one prime
    function automatic divisor_result_t count_divisors(input logic [NUMBER_WIDTH-1:0] number);
        longint unsigned remaining;
        longint unsigned trial;
        longint unsigned powers;
        longint unsigned total;
        divisor_result_t result;
        result.number = number;
        remaining     = longint'(number) & VALUE_MASK;
        if (remaining == 0)
        begin
            result.count     = '0;
            result.bad_input = 1'b1;
        end
        else
        begin
            total = 1;
            for (trial = 2; trial * trial <= remaining; trial++)
            begin
                powers = 1;
                while (remaining % trial == 0)
                begin
                    remaining = remaining / trial;
                    powers++;
                end
                total = total * powers;
            end
            if (remaining > 1)
                total = total * 2;
            if (total > COUNT_MAX)
                total = COUNT_MAX;
            result.count     = total[COUNT_WIDTH-1:0];
            result.bad_input = 1'b0;
        end
        return result;
    endfunction

    task automatic report_mismatch(input string message);
        $display("[%0t] ERROR: %s", $realtime, message);
        mismatches++;
    endtask

    // Retire the result beat before queuing the number beat of the same edge:
    // a result can never belong to a number taken at the very same edge
    always @(posedge clk)
    begin
        divisor_result_t oldest;
        if (!rst_n)
        begin
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch($sformatf("result beat with no number waiting: count %0d flag %0d",
                                              m_tdata, m_tuser));
                else
                begin
                    oldest = pending_counts.pop_front();
                    if (m_tdata !== oldest.count)
                        report_mismatch($sformatf("number %0d: count %0d, expected %0d",
                                                  oldest.number, m_tdata, oldest.count));
                    if (m_tuser[0] !== oldest.bad_input)
                        report_mismatch($sformatf("number %0d: bad_input %0d, expected %0d",
                                                  oldest.number, m_tuser[0], oldest.bad_input));
                end
            end
            if (s_tvalid && s_tready)
                pending_counts.push_back(count_divisors(s_tdata));
            outstanding = pending_counts.size();
        end
    end

endmodule

>>> sim/divisor_count_tb.sv
`timescale 1ns / 100ps

module divisor_count_tb;
    import dc_pkg::*;

    localparam int VALUE_BITS = 16;

    // Cycles without any accepted beat before the run is declared hung.
    // It covers the slowest number (a prime near the top of the range)
    // and the long receiver hold-off several times over.
    localparam int HANG_LIMIT    = 40000;
    localparam int RX_HOLD_LEN   = 1000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 28;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [NUMBER_WIDTH-1:0] s_tdata;   // [15:0] number
    logic                    m_tvalid;
    logic                    m_tready;
    logic [COUNT_WIDTH-1:0]  m_tdata;   // [7:0] divisor_count
    logic [0:0]              m_tuser;   // [0] bad_input

    int mismatches;
    int outstanding;

    // Idle rates in percent for each side, and a one-time request for
    // the long receiver hold-off, which the receiver process counts out itself
    int   sender_idle_pct;
    int   receiver_stall_pct;
    logic rx_hold_req;

    divisor_count #(
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    divisor_count_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one number and hold it until the block takes it. Call at a rising
    // edge. An idle gap, if any, is drawn before raising tvalid so that tvalid
    // gets a single assignment per edge.
    task automatic offer_number(input logic [NUMBER_WIDTH-1:0] number);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random number with a mix of shapes: full range for bit coverage, small
    // values, smooth products of small primes, perfect squares, and the edges
    function automatic logic [NUMBER_WIDTH-1:0] pick_number();
        int unsigned small_primes [6] = '{2, 3, 5, 7, 11, 13};
        int unsigned value;
        int unsigned factor;
        int unsigned shape;
        shape = $urandom_range(99);
        if (shape < 35)
            value = $urandom_range(65535);
        else if (shape < 65)
            value = $urandom_range(255);
        else if (shape < 85)
        begin
            value = 1;
            repeat ($urandom_range(1, 14))
            begin
                factor = small_primes[$urandom_range(5)];
                if (value * factor <= 65535)
                    value = value * factor;
            end
        end
        else if (shape < 95)
        begin
            value = $urandom_range(2, 255);
            value = value * value;
        end
        else
            value = $urandom_range(1);
        return value[NUMBER_WIDTH-1:0];
    endfunction

    // Receiver: run the requested hold-off once, else stall at the phase rate
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = RX_HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            @(posedge clk);
        end
    end

    // Watchdog: count edges at which neither side moves a beat
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [NUMBER_WIDTH-1:0] directed_numbers [$];
        int                      phase_sender [4]   = '{0, 70, 0, 13};
        int                      phase_receiver [4] = '{0, 0, 70, 13};

        s_tvalid           <= 1'b0;
        s_tdata            <= '0;
        rst_n              <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rx_hold_req        = 1'b0;

        // Zero and one, small primes and powers, the largest prime, a prime
        // square, a product of two large primes, a prime cube, highly composite
        // values, and the all-ones value
        directed_numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd49,
                             16'd65535, 16'd65534, 16'd65521, 16'd63001, 16'd64507,
                             16'd65025, 16'd29791, 16'd32768, 16'd55440, 16'd45360,
                             16'd30030, 16'd0, 16'd1};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i])
            offer_number(directed_numbers[i]);
        s_tvalid <= 1'b0;

        // Pause the sender until every directed result is back; step one edge
        // first so the last number taken is already counted as outstanding
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);

        // Back-pressure: the receiver holds off while quick small numbers keep
        // coming, so the output register and the sequencer fill and s_tready drops
        rx_hold_req = 1'b1;
        repeat (10)
            offer_number(NUMBER_WIDTH'($urandom_range(1, 63)));

        // Random phases, one per idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = phase_sender[phase];
            receiver_stall_pct = phase_receiver[phase];
            repeat (PHASE_ITEMS)
                offer_number(pick_number());
        end
        s_tvalid <= 1'b0;

        // Drain, then linger so a stray extra result beat would be caught
        receiver_stall_pct = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hdl/dc_pkg.sv
hdl/dc_divider.sv
hdl/divisor_count.sv
sim/divisor_count_checker.sv
sim/divisor_count_tb.sv
